@@ design/leb_pkg.sv @@
`timescale 1ns / 1ps

package leb_pkg;

	// Integer kinds carried on the input kind field.
	typedef enum logic [2:0] {
		KIND_U32 = 3'd0,
		KIND_U64 = 3'd1,
		KIND_S32 = 3'd2,
		KIND_S33 = 3'd3,
		KIND_S64 = 3'd4
	} kind_t;

	// Error codes carried with each result.
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_TOO_LONG  = 2'd1,
		ERR_TOO_LARGE = 2'd2,
		ERR_END       = 2'd3
	} err_t;

	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned OFFSET_W = 7;
	localparam int unsigned GROUP_W  = 7;

	// Offsets of the last group that an unsigned kind may carry.
	localparam logic [OFFSET_W-1:0] LAST_OFF_U32 = 7'd28;
	localparam logic [OFFSET_W-1:0] LAST_OFF_U64 = 7'd63;

	// Payload bits that must be clear in the last group of an unsigned kind.
	localparam logic [GROUP_W-1:0] BIG_MASK_U32 = 7'h70;
	localparam logic [GROUP_W-1:0] BIG_MASK_U64 = 7'h7E;

	// Bit widths of the signed kinds.
	localparam logic [OFFSET_W-1:0] WIDTH_S32 = 7'd32;
	localparam logic [OFFSET_W-1:0] WIDTH_S33 = 7'd33;
	localparam logic [OFFSET_W-1:0] WIDTH_S64 = 7'd64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

endpackage

@@ design/leb128_integer_decoder.sv @@
`timescale 1ns / 1ps

// LEB128 integer decoder. Encoded bytes enter one per request on the slave
// side; the integer kind is taken from the first byte of each value. A result
// leaves on the master side for every final byte, every error and every
// request that follows an error, since errors stay until reset. The block
// takes one byte per cycle, save for the stall below: the byte is
// registered, then the decode of that byte against the running accumulator
// is registered into the result register. The accumulator update
// is the loop that sets this rate; it holds one shift, one OR and a few small
// compares. A request stalls only while a result waits in the result register
// and the registered byte needs to produce another one.
module leb128_integer_decoder
	import leb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [3:0]  s_tuser,   // [2:0] kind, [3] at_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] value, [67:64] byte_count, rest zero
	output logic [1:0]  m_tuser    // [1:0] error
);

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  kind_s1;
	logic        end_s1;

	// Decoder state.
	logic [VALUE_W-1:0]  acc_q;
	logic [OFFSET_W-1:0] off_q;
	logic [COUNT_W-1:0]  seen_q;
	logic [2:0]          kind_q;
	logic                in_value_q;
	err_t                sticky_q;

	// Result register.
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [COUNT_W-1:0] out_count_q;
	err_t               out_err_q;

	// Decode of the registered byte.
	logic                res_valid;
	logic [VALUE_W-1:0]  res_value;
	logic [COUNT_W-1:0]  res_count;
	err_t                res_err;
	logic [VALUE_W-1:0]  nx_acc;
	logic [OFFSET_W-1:0] nx_off;
	logic [COUNT_W-1:0]  nx_seen;
	logic [2:0]          nx_kind;
	logic                nx_in_value;
	err_t                nx_sticky;

	logic                advance_s1;
	logic                load_s1;

	logic [2:0]          k;
	logic [VALUE_W-1:0]  acc0;
	logic [OFFSET_W-1:0] off0;
	logic [COUNT_W-1:0]  seen0;
	logic [COUNT_W-1:0]  seen1;
	logic [VALUE_W-1:0]  group_sh;
	logic [VALUE_W-1:0]  acc_or;
	logic [OFFSET_W-1:0] last_off;
	logic [GROUP_W-1:0]  big_mask;
	logic [OFFSET_W-1:0] width_n;
	logic [OFFSET_W-1:0] rem;
	logic [2:0]          eff;
	logic [GROUP_W-1:0]  ext_mask;
	logic [GROUP_W-1:0]  ext_bits;
	logic [VALUE_W-1:0]  payload;
	logic [VALUE_W-1:0]  sval;
	logic                is_signed;

	// Kind and start-of-value selection shared by both decode paths.
	always_comb begin
		k     = in_value_q ? kind_q : kind_s1;
		acc0  = in_value_q ? acc_q : '0;
		off0  = in_value_q ? off_q : '0;
		seen0 = in_value_q ? seen_q : '0;
		seen1 = (seen0 < COUNT_MAX) ? seen0 + COUNT_W'(1) : seen0;
		group_sh = {{(VALUE_W-GROUP_W){1'b0}}, byte_s1[GROUP_W-1:0]} << off0;
		acc_or   = acc0 | group_sh;
		is_signed = (k == KIND_S32) || (k == KIND_S33) || (k == KIND_S64);
		last_off = (k == KIND_U32) ? LAST_OFF_U32 : LAST_OFF_U64;
		big_mask = (k == KIND_U32) ? BIG_MASK_U32 : BIG_MASK_U64;
		case (k)
			KIND_S32: width_n = WIDTH_S32;
			KIND_S33: width_n = WIDTH_S33;
			default:  width_n = WIDTH_S64;
		endcase
		rem = width_n - off0;
		eff = (rem < OFFSET_W'(GROUP_W)) ? rem[2:0] : 3'(GROUP_W);
		// Bits from the sign position of the last group up must all match.
		ext_mask = GROUP_W'({GROUP_W{1'b1}} << (eff - 3'd1));
		ext_bits = byte_s1[GROUP_W-1:0] & ext_mask;
		payload  = {{(VALUE_W-GROUP_W){byte_s1[6]}}, byte_s1[GROUP_W-1:0]};
		sval     = acc0 | (payload << off0);
		if (k == KIND_S32) begin
			sval = {{32{sval[31]}}, sval[31:0]};
		end
	end

	// One decode step: result and next state.
	always_comb begin
		res_valid   = 1'b0;
		res_value   = '0;
		res_count   = seen1;
		res_err     = ERR_NONE;
		nx_acc      = acc_or;
		nx_off      = off0 + OFFSET_W'(GROUP_W);
		nx_seen     = seen1;
		nx_kind     = k;
		nx_in_value = 1'b1;
		nx_sticky   = sticky_q;
		if (sticky_q != ERR_NONE) begin
			// Errors repeat and leave the state alone.
			res_valid   = 1'b1;
			res_count   = '0;
			res_err     = sticky_q;
			nx_acc      = acc_q;
			nx_off      = off_q;
			nx_seen     = seen_q;
			nx_kind     = kind_q;
			nx_in_value = in_value_q;
		end else if (end_s1) begin
			res_valid   = 1'b1;
			res_count   = seen_q;
			res_err     = ERR_END;
			nx_acc      = acc_q;
			nx_off      = off_q;
			nx_seen     = seen_q;
			nx_kind     = kind_q;
			nx_in_value = 1'b0;
			nx_sticky   = ERR_END;
		end else if (!is_signed) begin
			if (off0 > last_off) begin
				res_valid = 1'b1;
				res_err   = ERR_TOO_LONG;
			end else if (off0 == last_off && (byte_s1[GROUP_W-1:0] & big_mask) != '0) begin
				res_valid = 1'b1;
				res_err   = ERR_TOO_LARGE;
			end else if (byte_s1[7]) begin
				if (off0 == last_off) begin
					res_valid = 1'b1;
					res_err   = ERR_TOO_LONG;
				end
			end else begin
				res_valid = 1'b1;
				res_value = (k == KIND_U32) ? {32'd0, acc_or[31:0]} : acc_or;
			end
			if (res_valid) begin
				nx_in_value = 1'b0;
				nx_sticky   = res_err;
			end
		end else begin
			if (off0 >= width_n) begin
				res_valid = 1'b1;
				res_err   = ERR_TOO_LONG;
			end else if (byte_s1[7]) begin
				if (rem < OFFSET_W'(GROUP_W)) begin
					res_valid = 1'b1;
					res_err   = ERR_TOO_LONG;
				end
			end else if (ext_bits != '0 && ext_bits != ext_mask) begin
				res_valid = 1'b1;
				res_err   = ERR_TOO_LARGE;
			end else begin
				res_valid = 1'b1;
				res_value = sval;
			end
			if (res_valid) begin
				nx_in_value = 1'b0;
				nx_sticky   = res_err;
			end
		end
	end

	// The registered byte moves on unless its result would overwrite a waiting one.
	assign advance_s1 = valid_s1 && (!res_valid || !out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;
	assign load_s1    = s_tvalid && s_tready;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= s_tdata;
			kind_s1 <= s_tuser[2:0];
			end_s1  <= s_tuser[3];
		end
	end

	// Decoder state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			off_q      <= '0;
			seen_q     <= '0;
			kind_q     <= '0;
			in_value_q <= 1'b0;
			sticky_q   <= ERR_NONE;
		end else if (advance_s1) begin
			acc_q      <= nx_acc;
			off_q      <= nx_off;
			seen_q     <= nx_seen;
			kind_q     <= nx_kind;
			in_value_q <= nx_in_value;
			sticky_q   <= nx_sticky;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance_s1 && res_valid) begin
			out_value_q <= res_value;
			out_count_q <= res_count;
			out_err_q   <= res_err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_count_q, out_value_q};
	assign m_tuser  = out_err_q;

	// An error, once taken, never changes until reset.
	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != ERR_NONE |=> sticky_q == $past(sticky_q))
		else $error("sticky error changed");

	// No value stays open once an error is taken.
	a_sticky_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != ERR_NONE |-> !in_value_q)
		else $error("value in progress after error");

	// Error results carry a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ERR_NONE |-> m_tdata[63:0] == '0)
		else $error("error result with nonzero value");

	// A good result uses at least one byte.
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ERR_NONE |-> m_tdata[67:64] != '0)
		else $error("good result with zero byte count");

endmodule

@@ tb/sv/tb_leb128_integer_decoder.sv @@
`timescale 1ns / 1ps

module tb_leb128_integer_decoder;
	import leb_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned PHASE_BYTES  = 370;
	localparam int unsigned PRINT_CAP    = 40;

	// One encoded byte request and one decoded integer result.
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
		logic       at_end;
	} enc_byte_t;

	typedef struct packed {
		logic [63:0]        value;
		logic [COUNT_W-1:0] count;
		err_t               error;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
	logic [3:0]  s_tuser = 4'd0;   // [2:0] kind, [3] at_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;          // [63:0] value, [67:64] byte_count, rest zero
	logic [1:0]  m_tuser;          // [1:0] error

	enc_byte_t   enc_bytes[$];
	decoded_t    decoded_due[$];
	enc_byte_t   next_byte;
	int unsigned bytes_pushed = 0;
	int unsigned fail_count = 0;
	int unsigned cycles = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_tab[4]  = '{0, 86, 0, 21};
	int unsigned stall_tab[4] = '{0, 0, 86, 21};

	// Decoder state mirrored by the predictor.
	logic [63:0]        acc;
	int unsigned        off;
	logic [COUNT_W-1:0] seen;
	logic [2:0]         lkind;
	logic               busy;
	err_t               sticky;

	leb128_integer_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic kind_is_signed(input logic [2:0] k);
		return (k == KIND_S32) || (k == KIND_S33) || (k == KIND_S64);
	endfunction

	function automatic int unsigned kind_width(input logic [2:0] k);
		if (k == KIND_S32) begin
			return 32'(WIDTH_S32);
		end else if (k == KIND_S33) begin
			return 32'(WIDTH_S33);
		end
		return 32'(WIDTH_S64);
	endfunction

	function automatic int unsigned kind_max_len(input logic [2:0] k);
		return (k == KIND_U32 || k == KIND_S32 || k == KIND_S33) ? 5 : 10;
	endfunction

	function automatic logic [6:0] pick_group(input int unsigned fill);
		case (fill)
			0: begin
				return 7'h00;
			end
			1: begin
				return 7'h7F;
			end
			default: begin
				return 7'($urandom);
			end
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] data, input logic [2:0] kind,
			input logic at_end);
		enc_bytes.push_back('{data: data, kind: kind, at_end: at_end});
		bytes_pushed++;
	endtask

	// Queue a result and record the error that sticks from now on.
	task automatic decode_fail(input err_t err);
		sticky = err;
		busy = 1'b0;
		decoded_due.push_back('{value: 64'd0, count: seen, error: err});
	endtask

	task automatic decode_done(input logic [63:0] v);
		busy = 1'b0;
		decoded_due.push_back('{value: v, count: seen, error: ERR_NONE});
	endtask

	// Predict the result, if any, of one accepted byte request.
	task automatic decode_step(input logic [7:0] b, input logic [2:0] k_in,
			input logic at_end);
		int unsigned last, n, rem, eff, bv;
		logic [6:0]  big;
		logic [63:0] payload, v;
		bv = 32'(b);
		if (sticky != ERR_NONE) begin
			decoded_due.push_back('{value: 64'd0, count: '0, error: sticky});
			return;
		end
		if (at_end) begin
			decode_fail(ERR_END);
			return;
		end
		if (!busy) begin
			lkind = k_in;
			acc = 64'd0;
			off = 0;
			seen = '0;
			busy = 1'b1;
		end
		if (seen < COUNT_MAX) seen++;

		if (!kind_is_signed(lkind)) begin
			// Unsigned kinds; spare codes behave as unsigned 64.
			last = 32'((lkind == KIND_U32) ? LAST_OFF_U32 : LAST_OFF_U64);
			big = (lkind == KIND_U32) ? BIG_MASK_U32 : BIG_MASK_U64;
			if (off > last) begin
				decode_fail(ERR_TOO_LONG);
				return;
			end
			acc = acc | ({57'd0, b[6:0]} << off);
			if (off == last && (b[6:0] & big) != '0) begin
				decode_fail(ERR_TOO_LARGE);
				return;
			end
			if (b[7]) begin
				if (off == last) begin
					decode_fail(ERR_TOO_LONG);
				end else begin
					off += GROUP_W;
				end
				return;
			end
			decode_done((lkind == KIND_U32) ? {32'd0, acc[31:0]} : acc);
		end else begin
			// Signed kinds: the final group must be a valid sign extension.
			n = kind_width(lkind);
			if (off >= n) begin
				decode_fail(ERR_TOO_LONG);
				return;
			end
			rem = n - off;
			if (b[7]) begin
				if (rem < GROUP_W) begin
					decode_fail(ERR_TOO_LONG);
					return;
				end
				acc = acc | ({57'd0, b[6:0]} << off);
				off += GROUP_W;
				return;
			end
			eff = (rem < GROUP_W) ? rem : GROUP_W;
			payload = {56'd0, b};
			if (b[6]) begin
				if (bv >= 128 - (1 << (eff - 1))) begin
					payload = payload - 64'd128;
				end else begin
					decode_fail(ERR_TOO_LARGE);
					return;
				end
			end else if (bv >= (1 << (eff - 1))) begin
				decode_fail(ERR_TOO_LARGE);
				return;
			end
			v = acc | (payload << off);
			if (lkind == KIND_S32) v = {{32{v[31]}}, v[31:0]};
			decode_done(v);
		end
	endtask

	// Queue one well-formed encoding of random length and content.
	task automatic push_varint(input logic [2:0] k);
		int unsigned maxlen, len, fill, o, rem, eff, lo;
		logic [6:0]  mask;
		logic [7:0]  b;
		maxlen = kind_max_len(k);
		len = ($urandom_range(3) == 0) ? maxlen : $urandom_range(maxlen, 1);
		fill = $urandom_range(3);
		for (int i = 0; i < len - 1; i++) begin
			push_byte({1'b1, pick_group(fill)}, (i == 0) ? k : 3'($urandom_range(7)),
				1'b0);
		end
		o = GROUP_W * (len - 1);
		if (kind_is_signed(k)) begin
			rem = kind_width(k) - o;
			eff = (rem < GROUP_W) ? rem : GROUP_W;
			lo = 1 << (eff - 1);
			if ($urandom_range(1) != 0) begin
				b = 8'(128 - lo + ($urandom & (lo - 1)));
			end else begin
				b = 8'($urandom & (lo - 1));
			end
		end else begin
			mask = 7'h7F;
			if (k == KIND_U32 && o == 32'(LAST_OFF_U32)) mask = ~BIG_MASK_U32;
			if (k != KIND_U32 && o == 32'(LAST_OFF_U64)) mask = ~BIG_MASK_U64;
			b = {1'b0, pick_group(fill) & mask};
		end
		push_byte(b, (len == 1) ? k : 3'($urandom_range(7)), 1'b0);
	endtask

	// Queue one encoding that ends in an error of a random class.
	task automatic push_faulty_varint();
		int unsigned sel, maxlen, rem, eff, lo;
		logic [2:0]  k;
		logic [7:0]  b;
		sel = $urandom_range(2);
		k = 3'($urandom_range(7));
		maxlen = kind_max_len(k);
		case (sel)
			0: begin
				// Data ends, possibly in the middle of a value.
				lo = $urandom_range(3);
				for (int i = 0; i < lo; i++) begin
					push_byte({1'b1, 7'($urandom)}, (i == 0) ? k : 3'($urandom_range(7)),
						1'b0);
				end
				push_byte(8'($urandom), 3'($urandom_range(7)), 1'b1);
			end
			1: begin
				// A continuation byte where the value must end.
				for (int i = 0; i < maxlen; i++) begin
					b = {1'b1, 7'($urandom)};
					if (i == maxlen - 1 && !kind_is_signed(k)) begin
						b[6:0] = b[6:0] & ((k == KIND_U32) ? ~BIG_MASK_U32 : ~BIG_MASK_U64);
					end
					push_byte(b, (i == 0) ? k : 3'($urandom_range(7)), 1'b0);
				end
			end
			default: begin
				// A final byte with excess high bits.
				for (int i = 0; i < maxlen - 1; i++) begin
					push_byte({1'b1, 7'($urandom)}, (i == 0) ? k : 3'($urandom_range(7)),
						1'b0);
				end
				if (kind_is_signed(k)) begin
					rem = kind_width(k) - GROUP_W * (maxlen - 1);
					eff = (rem < GROUP_W) ? rem : GROUP_W;
					lo = 1 << (eff - 1);
					b = 8'($urandom_range(127 - lo, lo));
				end else begin
					b = {1'b0, 7'($urandom) | ((k == KIND_U32) ? 7'h10 : 7'h02)};
				end
				push_byte(b, 3'($urandom_range(7)), 1'b0);
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < PRINT_CAP) begin
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what,
				got, want);
		end
		fail_count++;
	endtask

	// Hold off the sender until the block has drained every result.
	task automatic drain_results();
		wait (enc_bytes.size() == 0 && !s_tvalid && decoded_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// Request driver: one byte per accepted handshake, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tuser <= 4'd0;
		end else begin
			if (s_tvalid && s_tready) decode_step(s_tdata, s_tuser[2:0], s_tuser[3]);
			if (!s_tvalid || s_tready) begin
				if (enc_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_byte = enc_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.data;
					s_tuser <= {next_byte.at_end, next_byte.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decoded_due.size() == 0) begin
					report_mismatch("result with none due, value", m_tdata[63:0], 64'd0);
				end else begin
					automatic decoded_t want = decoded_due.pop_front();
					if (m_tdata[63:0] !== want.value) begin
						report_mismatch("value", m_tdata[63:0], want.value);
					end
					if (m_tdata[67:64] !== want.count) begin
						report_mismatch("byte_count", 64'(m_tdata[67:64]), 64'(want.count));
					end
					if (m_tuser !== want.error) begin
						report_mismatch("error", 64'(m_tuser), 64'(want.error));
					end
					if (m_tdata[71:68] !== 4'd0) begin
						report_mismatch("padding", 64'(m_tdata[71:68]), 64'd0);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		acc = 64'd0;
		off = 0;
		seen = '0;
		lkind = 3'd0;
		busy = 1'b0;
		sticky = ERR_NONE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes of every kind, including the spare kind codes.
		repeat (4) push_byte(8'hFF, KIND_U32, 1'b0);
		push_byte(8'h0F, KIND_U32, 1'b0);
		repeat (9) push_byte(8'hFF, KIND_U64, 1'b0);
		push_byte(8'h01, KIND_U64, 1'b0);
		repeat (4) push_byte(8'h80, KIND_S32, 1'b0);
		push_byte(8'h78, KIND_S32, 1'b0);
		push_byte(8'h40, KIND_S33, 1'b0);
		push_byte(8'h7F, KIND_S64, 1'b0);
		for (int k = KIND_S64 + 1; k < 8; k++) begin
			push_byte({1'b0, 7'($urandom)}, 3'(k), 1'b0);
		end

		// Random well-formed values under each idling pattern.
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			while (bytes_pushed < 25 + (p + 1) * PHASE_BYTES) begin
				push_varint(3'($urandom_range(7)));
			end
			drain_results();
		end

		// One error, then requests that must all repeat it.
		idle_pct = 21;
		stall_pct = 21;
		push_faulty_varint();
		repeat (20) push_byte(8'($urandom), 3'($urandom_range(7)), 1'($urandom));
		drain_results();
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
